// ===== hdl/fpa_pkg.sv =====
// Fixed-point ALU package: operation codes, word limits and the item record
// that moves along the pipeline. No dependencies.

package fpa_pkg;

    localparam int WORD_W     = 32;
    localparam int KIND_W     = 4;
    localparam int OUT_DATA_W = 40;

    // Operation codes carried in s_axis_tuser
    localparam logic [KIND_W-1:0] KIND_ADD    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SUB    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MUL    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DIV    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_MIN    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_MAX    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_INC    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_DEC    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_TO_INT = 4'd8;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    // Decoded operation as it travels through the divider chain
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              neg;         // sign of product or quotient
        logic              b_zero;
        logic [WORD_W-1:0] mag_a;
        logic [WORD_W-1:0] mag_b;
        logic [WORD_W-1:0] simple_res;  // add/sub/min/max/inc/dec/to-int result
        logic              simple_ovf;
        logic              gt;
        logic              lt;
        logic              eq;
    } fpa_item_t;

endpackage

// ===== hdl/fpa_prep.sv =====
// Front stage: operand magnitudes, comparison flags and the simple
// operations, registered into the item record. Depends on fpa_pkg.

module fpa_prep import fpa_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] in_kind,
    input  logic [WORD_W-1:0] in_a,
    input  logic [WORD_W-1:0] in_b,
    output logic              out_valid,
    output fpa_item_t         out_item
);

    logic        valid_reg;
    fpa_item_t   item_reg;
    fpa_item_t   item_next;

    logic [WORD_W:0]   a_ext;
    logic [WORD_W:0]   y_ext;
    logic [WORD_W:0]   sum;
    logic              do_sub;
    logic [WORD_W-1:0] int_mag;

    always_comb begin
        // comparisons and magnitudes
        item_next.kind   = in_kind;
        item_next.gt     = $signed(in_a) > $signed(in_b);
        item_next.lt     = $signed(in_a) < $signed(in_b);
        item_next.eq     = in_a == in_b;
        item_next.neg    = in_a[WORD_W-1] ^ in_b[WORD_W-1];
        item_next.b_zero = in_b == '0;
        item_next.mag_a  = in_a[WORD_W-1] ? WORD_W'(32'd0 - in_a) : in_a;
        item_next.mag_b  = in_b[WORD_W-1] ? WORD_W'(32'd0 - in_b) : in_b;

        // one shared 33-bit adder for add, sub, inc and dec
        a_ext  = {in_a[WORD_W-1], in_a};
        do_sub = (in_kind == KIND_SUB) || (in_kind == KIND_DEC);
        y_ext  = ((in_kind == KIND_ADD) || (in_kind == KIND_SUB)) ?
                 {in_b[WORD_W-1], in_b} : (WORD_W+1)'(1);
        sum    = a_ext + (do_sub ? ~y_ext : y_ext) + (WORD_W+1)'(do_sub);

        int_mag = item_next.mag_a >> FRAC_BITS;

        item_next.simple_res = '0;
        item_next.simple_ovf = 1'b0;
        case (in_kind)
            KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC: begin
                if (sum[WORD_W] != sum[WORD_W-1]) begin
                    item_next.simple_ovf = 1'b1;
                    item_next.simple_res = sum[WORD_W] ? WORD_MIN : WORD_MAX;
                end else begin
                    item_next.simple_res = sum[WORD_W-1:0];
                end
            end
            KIND_MIN: item_next.simple_res = (item_next.lt || item_next.eq) ? in_a : in_b;
            KIND_MAX: item_next.simple_res = (item_next.gt || item_next.eq) ? in_a : in_b;
            KIND_TO_INT: begin
                item_next.simple_res = in_a[WORD_W-1] ? WORD_W'(32'd0 - int_mag) : int_mag;
            end
            default: item_next.simple_res = '0;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hdl/fpa_div_cell.sv =====
// One cell of the restoring divider chain: settles one quotient bit of
// (|a| << FRAC_BITS) / |b| and hands the item on. Depends on fpa_pkg.

module fpa_div_cell import fpa_pkg::*; #(
    parameter int FRAC_BITS = 8,
    parameter int BIT_IDX   = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  fpa_item_t                   in_item,
    input  logic [WORD_W+FRAC_BITS-1:0] in_quot,
    input  logic [WORD_W-1:0]           in_rem,
    output logic                        out_valid,
    output fpa_item_t                   out_item,
    output logic [WORD_W+FRAC_BITS-1:0] out_quot,
    output logic [WORD_W-1:0]           out_rem
);

    localparam int NUM_W = WORD_W + FRAC_BITS;

    logic                valid_reg;
    fpa_item_t           item_reg;
    logic [NUM_W-1:0]    quot_reg;
    logic [NUM_W-1:0]    quot_next;
    logic [WORD_W-1:0]   rem_reg;
    logic [WORD_W-1:0]   rem_next;
    logic                num_bit;
    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     diff;
    logic                fits;

    // numerator bit for this position: low FRAC_BITS bits are zero
    generate
        if (BIT_IDX < FRAC_BITS) begin : g_zero_bit
            assign num_bit = 1'b0;
        end else begin : g_mag_bit
            assign num_bit = in_item.mag_a[BIT_IDX-FRAC_BITS];
        end
    endgenerate

    // shift in one bit, trial subtract
    always_comb begin
        trial     = {in_rem, num_bit};
        diff      = trial - {1'b0, in_item.mag_b};
        fits      = trial >= {1'b0, in_item.mag_b};
        rem_next  = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        quot_next = {in_quot[NUM_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= in_item;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_quot  = quot_reg;
    assign out_rem   = rem_reg;

endmodule

// ===== hdl/fpa_finish.sv =====
// Back end: magnitude product stage, then rounding, saturation and result
// selection into the output register. Depends on fpa_pkg.

module fpa_finish import fpa_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  fpa_item_t                   in_item,
    input  logic [WORD_W+FRAC_BITS-1:0] in_quot,
    input  logic [WORD_W-1:0]           in_rem,
    output logic                        out_valid,
    output logic [OUT_DATA_W-1:0]       out_data
);

    localparam int          NUM_W = WORD_W + FRAC_BITS;
    localparam logic [63:0] HALF  = (64'd1 << FRAC_BITS) >> 1;

    // product stage
    logic             p_valid_reg;
    fpa_item_t        p_item_reg;
    logic [NUM_W-1:0] p_quot_reg;
    logic [WORD_W-1:0] p_rem_reg;
    logic [63:0]      prod_reg;
    logic [63:0]      prod_next;

    // output stage
    logic                  o_valid_reg;
    logic [OUT_DATA_W-1:0] o_data_reg;
    logic [OUT_DATA_W-1:0] o_data_next;

    logic [63:0]       mul_mag;
    logic              round_up;
    logic [NUM_W:0]    div_mag;
    logic [63:0]       mag;
    logic [WORD_W-1:0] sat_res;
    logic              sat_ovf;
    logic [WORD_W-1:0] res;
    logic              ovf;
    logic              dz;

    assign prod_next = 64'(in_item.mag_a) * 64'(in_item.mag_b);

    always_comb begin
        // round half away from zero on magnitudes
        mul_mag  = (prod_reg + HALF) >> FRAC_BITS;
        round_up = {p_rem_reg, 1'b0} >= {1'b0, p_item_reg.mag_b};
        div_mag  = {1'b0, p_quot_reg} + (NUM_W+1)'(round_up);
        mag      = (p_item_reg.kind == KIND_MUL) ? mul_mag :
                   {{(63-NUM_W){1'b0}}, div_mag};

        // saturate signed result from sign and magnitude
        if (p_item_reg.neg) begin
            sat_ovf = mag > 64'h8000_0000;
            sat_res = sat_ovf ? WORD_MIN : WORD_W'(32'd0 - mag[WORD_W-1:0]);
        end else begin
            sat_ovf = mag > 64'h7FFF_FFFF;
            sat_res = sat_ovf ? WORD_MAX : mag[WORD_W-1:0];
        end

        res = p_item_reg.simple_res;
        ovf = p_item_reg.simple_ovf;
        dz  = 1'b0;
        case (p_item_reg.kind)
            KIND_MUL: begin
                res = sat_res;
                ovf = sat_ovf;
            end
            KIND_DIV: begin
                if (p_item_reg.b_zero) begin
                    res = '0;
                    ovf = 1'b0;
                    dz  = 1'b1;
                end else begin
                    res = sat_res;
                    ovf = sat_ovf;
                end
            end
            default: ;
        endcase

        o_data_next = {3'b000, dz, ovf, p_item_reg.eq, p_item_reg.lt, p_item_reg.gt, res};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= in_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_item_reg <= in_item;
            p_quot_reg <= in_quot;
            p_rem_reg  <= in_rem;
            prod_reg   <= prod_next;
            o_data_reg <= o_data_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

// ===== hdl/fixed_point_alu_unit.sv =====
// Throughput: one operation per cycle while no result waits; the restoring divider
// is a chain of 32 + FRAC_BITS cells, one quotient bit each, and every operation
// runs it. The whole pipeline moves in lockstep and holds while a result waits.
// Reset: synchronous, active low; clears all stage valid bits only.
// Depends on fpa_pkg, fpa_prep, fpa_div_cell and fpa_finish.

module fixed_point_alu_unit import fpa_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
    input  logic [KIND_W-1:0]     s_axis_tuser,  // [3:0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] result_raw, [32] a_greater, [33] a_less, [34] a_equal,
    // [35] overflowed, [36] divide_by_zero, [39:37] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int NUM_W = WORD_W + FRAC_BITS;

    logic              adv;
    logic              chain_valid [0:NUM_W];
    fpa_item_t         chain_item  [0:NUM_W];
    logic [NUM_W-1:0]  chain_quot  [0:NUM_W];
    logic [WORD_W-1:0] chain_rem   [0:NUM_W];

    // lockstep advance: move whenever the output register is free or drained
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    fpa_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_a      (s_axis_tdata[31:0]),
        .in_b      (s_axis_tdata[63:32]),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0])
    );

    assign chain_quot[0] = '0;
    assign chain_rem[0]  = '0;

    // divider chain, most significant quotient bit first
    generate
        for (genvar i = 0; i < NUM_W; i++) begin : g_cell
            fpa_div_cell #(
                .FRAC_BITS (FRAC_BITS),
                .BIT_IDX   (NUM_W - 1 - i)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .adv       (adv),
                .in_valid  (chain_valid[i]),
                .in_item   (chain_item[i]),
                .in_quot   (chain_quot[i]),
                .in_rem    (chain_rem[i]),
                .out_valid (chain_valid[i+1]),
                .out_item  (chain_item[i+1]),
                .out_quot  (chain_quot[i+1]),
                .out_rem   (chain_rem[i+1])
            );
        end
    endgenerate

    fpa_finish #(
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (chain_valid[NUM_W]),
        .in_item   (chain_item[NUM_W]),
        .in_quot   (chain_quot[NUM_W]),
        .in_rem    (chain_rem[NUM_W]),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== hdl/fpa_checker.sv =====
// Port-level checks on the fixed-point ALU result stream, bound to the top
// level. Depends on fpa_pkg and fixed_point_alu_unit.

module fpa_port_checks import fpa_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // no result shows straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // exactly one comparison flag per result
    a_cmp_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $onehot(m_axis_tdata[34:32]))
        else $error("comparison flags not one-hot");

    // divide by zero gives zero and no overflow
    a_dz_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[36]) |->
            (!m_axis_tdata[35] && (m_axis_tdata[31:0] == 32'd0)))
        else $error("divide by zero result wrong");

    // saturated results sit at a word limit
    a_ovf_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[35]) |->
            ((m_axis_tdata[31:0] == WORD_MAX) || (m_axis_tdata[31:0] == WORD_MIN)))
        else $error("overflow without saturated result");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind fixed_point_alu_unit fpa_port_checks u_fpa_port_checks (.*);

// ===== sim/fpa_checker.sv =====
// Result checker for the fixed-point ALU: watches both stream channels,
// predicts each result from the accepted operation and compares in order.
// Depends on fpa_pkg for widths and operation codes.

module fpa_checker import fpa_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
    input  logic [KIND_W-1:0]     s_axis_tuser,  // [3:0] kind
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] result_raw, [32] a_greater, [33] a_less, [34] a_equal,
    // [35] overflowed, [36] divide_by_zero, [39:37] zero
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int unsigned           error_count,
    output int unsigned           outstanding,
    output int unsigned           results_checked,
    output int unsigned           saturations,
    output int unsigned           zero_divides
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam int     REPORT_MAX = 10;

    // Result word as it leaves the block, lowest field last
    typedef struct packed {
        logic [2:0]        pad;
        logic              dz;
        logic              ovf;
        logic              eq;
        logic              lt;
        logic              gt;
        logic [WORD_W-1:0] res;
    } alu_result_t;

    // One accepted operation together with its predicted result
    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        alu_result_t       want;
    } alu_op_t;

    alu_op_t result_q[$];

    // Saturate a wide signed value to a word: {overflow, word}
    function automatic logic [32:0] clamp_word(longint v);
        if (v > SAT_HI) return {1'b1, WORD_MAX};
        if (v < SAT_LO) return {1'b1, WORD_MIN};
        return {1'b0, v[31:0]};
    endfunction

    // Signed word from sign and magnitude, saturating: {overflow, word}
    function automatic logic [32:0] word_from_mag(logic neg, logic [63:0] mag);
        logic [31:0] w;
        if (neg) begin
            if (mag > 64'h8000_0000) return {1'b1, WORD_MIN};
            w = -mag[31:0];
            return {1'b0, w};
        end
        if (mag > 64'h7FFF_FFFF) return {1'b1, WORD_MAX};
        return {1'b0, mag[31:0]};
    endfunction

    // Expected result of one operation
    function automatic alu_result_t predict_alu(logic [KIND_W-1:0] op,
                                                logic signed [31:0] a,
                                                logic signed [31:0] b);
        alu_result_t r;
        longint      sa;
        longint      sb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] prod;
        logic [63:0] num;
        logic [63:0] half;
        logic [32:0] ow;
        r  = '0;
        ow = '0;
        sa = a;
        sb = b;
        ma = (sa < 0) ? 64'(-sa) : 64'(sa);
        mb = (sb < 0) ? 64'(-sb) : 64'(sb);
        case (op)
            KIND_ADD: ow = clamp_word(sa + sb);
            KIND_SUB: ow = clamp_word(sa - sb);
            KIND_MUL: begin
                // exact product, rounded half away from zero
                prod = ma * mb;
                half = (64'd1 << FRAC_BITS) >> 1;
                ow   = word_from_mag((sa < 0) != (sb < 0), (prod + half) >> FRAC_BITS);
            end
            KIND_DIV: begin
                if (sb == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num = ma << FRAC_BITS;
                    ow  = word_from_mag((sa < 0) != (sb < 0),
                                        (64'd2 * num + mb) / (64'd2 * mb));
                end
            end
            KIND_MIN:    ow = {1'b0, (sa <= sb) ? a : b};
            KIND_MAX:    ow = {1'b0, (sa >= sb) ? a : b};
            KIND_INC:    ow = clamp_word(sa + 1);
            KIND_DEC:    ow = clamp_word(sa - 1);
            KIND_TO_INT: ow = word_from_mag(sa < 0, ma >> FRAC_BITS);
            default:     ow = '0;
        endcase
        r.res = ow[31:0];
        r.ovf = ow[32];
        r.gt  = sa > sb;
        r.lt  = sa < sb;
        r.eq  = sa == sb;
        return r;
    endfunction

    // Count a failure; only the first few are printed
    task automatic log_fault(string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Predict on every input transfer, compare on every result transfer
    always @(posedge aclk) begin : score
        alu_result_t got;
        alu_op_t     head;
        if (!aresetn) begin
            result_q.delete();
            error_count     = 0;
            outstanding     = 0;
            results_checked = 0;
            saturations     = 0;
            zero_divides    = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                head.op   = s_axis_tuser;
                head.a    = s_axis_tdata[31:0];
                head.b    = s_axis_tdata[63:32];
                head.want = predict_alu(s_axis_tuser, s_axis_tdata[31:0],
                                        s_axis_tdata[63:32]);
                result_q.push_back(head);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                results_checked++;
                if (result_q.size() == 0) begin
                    log_fault($sformatf("result with nothing pending: %h", m_axis_tdata));
                end else begin
                    head = result_q.pop_front();
                    if (head.want.ovf) saturations++;
                    if (head.want.dz) zero_divides++;
                    if (got !== head.want)
                        log_fault($sformatf({"mismatch op %0d a %h b %h: expected res %h ",
                            "gt/lt/eq %b%b%b ovf %b dz %b, got res %h gt/lt/eq %b%b%b ",
                            "ovf %b dz %b pad %b"}, head.op, head.a, head.b,
                            head.want.res, head.want.gt, head.want.lt, head.want.eq,
                            head.want.ovf, head.want.dz, got.res, got.gt, got.lt,
                            got.eq, got.ovf, got.dz, got.pad));
                end
            end
            outstanding = result_q.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for fixed_point_alu_unit: clock, reset, operation stimulus
// with bursty source and stalling sink, and the final verdict.
// Depends on fpa_pkg, the unit under test and fpa_checker.

module tb_top import fpa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC_BITS   = 8;
    localparam int          LATENCY     = FRAC_BITS + 35;
    localparam int          CLK_PERIOD  = 20;
    localparam int          RESET_LEN   = 10;
    localparam int          LONG_HOLD   = 200;
    localparam int          PRESS_OPS   = 200;
    localparam int          RANDOM_OPS  = 1120;
    localparam int unsigned RUN_LIMIT   = 400000;

    // Codes the unit does not implement
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 4'd9;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 4'd15;

    typedef enum logic [1:0] {PH_DIRECTED, PH_RANDOM, PH_PRESSURE, PH_DRAIN} load_phase_t;
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_EVERY_THIRD} sink_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;   // [31:0] operand_a, [63:32] operand_b
    logic [KIND_W-1:0]     s_axis_tuser;   // [3:0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [31:0] result_raw, [32] a_greater, [33] a_less, [34] a_equal,
    // [35] overflowed, [36] divide_by_zero, [39:37] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int unsigned error_count;
    int unsigned outstanding;
    int unsigned results_checked;
    int unsigned saturations;
    int unsigned zero_divides;
    int unsigned ops_sent;
    load_phase_t load_phase;

    fixed_point_alu_unit #(.FRAC_BITS(FRAC_BITS)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fpa_checker #(.FRAC_BITS(FRAC_BITS)) alu_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .saturations     (saturations),
        .zero_divides    (zero_divides)
    );

    // Clock
    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Offer one operation from this edge and return at the edge of its transfer
    task automatic send_op(logic [KIND_W-1:0] op, logic [31:0] a, logic [31:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        ops_sent++;
    endtask

    // Operand mix: edge values, small and medium magnitudes, full range
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            case ($urandom_range(0, 6))
                0:       w = WORD_MAX;
                1:       w = WORD_MIN;
                2:       w = 32'd0;
                3:       w = 32'd1;
                4:       w = 32'hFFFF_FFFF;
                5:       w = 32'd256;
                default: w = 32'hFFFF_FF00;
            endcase
        end else if (sel < 45) begin
            w = $urandom_range(0, 8191);
            w = w - 32'd4096;
        end else if (sel < 65) begin
            w = $urandom_range(0, (1 << 21) - 1);
            w = w - 32'd1048576;
        end else begin
            w = $urandom;
        end
        return w;
    endfunction

    task automatic send_random_op();
        logic [KIND_W-1:0] op;
        logic [31:0]       a;
        logic [31:0]       b;
        if ($urandom_range(0, 19) == 0)
            op = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        else
            op = KIND_W'($urandom_range(KIND_ADD, KIND_TO_INT));
        a = pick_word();
        b = ($urandom_range(0, 9) == 0) ? a : pick_word();
        send_op(op, a, b);
    endtask

    // Random operations in bursts with idle gaps between them
    task automatic run_random(int unsigned count);
        int unsigned left;
        int unsigned burst;
        int unsigned gap;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 40);
            if (burst > left) burst = left;
            repeat (burst) send_random_op();
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Result sink: stall patterns of random length, one long hold-off
    initial begin : result_sink
        int unsigned span;
        sink_mode_t  mode;
        bit          long_hold_done;
        span           = 0;
        mode           = SINK_OPEN;
        long_hold_done = 1'b0;
        m_axis_tready  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (load_phase == PH_PRESSURE && !long_hold_done) begin
                // hold off while the source keeps offering, so the pipe fills
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else begin
                if (span == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(20, 150);
                end
                span--;
                case (mode)
                    SINK_OPEN:   m_axis_tready <= 1'b1;
                    SINK_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 0);
                    SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_axis_tready <= (span % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < RUN_LIMIT; cycles++) @(posedge aclk);
        $display("timeout after %0d cycles", RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Stimulus and verdict
    initial begin : stimulus
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ADD;
        load_phase    = PH_DIRECTED;
        ops_sent      = 0;
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: saturation at both limits, rounding ties, zero divisor
        send_op(KIND_ADD,    WORD_MAX,     32'd1);
        send_op(KIND_ADD,    WORD_MIN,     32'hFFFF_FFFF);
        send_op(KIND_ADD,    32'd0,        32'd0);
        send_op(KIND_SUB,    WORD_MIN,     32'd1);
        send_op(KIND_SUB,    WORD_MAX,     32'hFFFF_FFFF);
        send_op(KIND_MUL,    WORD_MAX,     WORD_MAX);
        send_op(KIND_MUL,    WORD_MIN,     WORD_MIN);
        send_op(KIND_MUL,    WORD_MIN,     32'd256);
        send_op(KIND_MUL,    32'd1,        32'd128);
        send_op(KIND_MUL,    32'hFFFF_FFFF, 32'd128);
        send_op(KIND_DIV,    32'd5,        32'd0);
        send_op(KIND_DIV,    WORD_MIN,     32'hFFFF_FF00);
        send_op(KIND_DIV,    32'd1,        32'd512);
        send_op(KIND_DIV,    32'hFFFF_FFFF, 32'd512);
        send_op(KIND_DIV,    WORD_MAX,     32'd1);
        send_op(KIND_DIV,    32'd0,        WORD_MIN);
        send_op(KIND_MIN,    32'hFFFF_FFF9, 32'hFFFF_FFF9);
        send_op(KIND_MIN,    WORD_MAX,     WORD_MIN);
        send_op(KIND_MAX,    WORD_MIN,     WORD_MAX);
        send_op(KIND_INC,    WORD_MAX,     32'd0);
        send_op(KIND_INC,    32'hFFFF_FFFF, WORD_MIN);
        send_op(KIND_DEC,    WORD_MIN,     32'd0);
        send_op(KIND_DEC,    32'd0,        WORD_MAX);
        send_op(KIND_TO_INT, WORD_MIN,     32'd3);
        send_op(KIND_TO_INT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(KIND_TO_INT, WORD_MAX,     32'd0);
        send_op(KIND_SPARE_FIRST, 32'd7,   32'd9);
        send_op(KIND_SPARE_LAST,  WORD_MIN, WORD_MIN);

        // Random, then a back-to-back run against a stalled sink, then random
        load_phase <= PH_RANDOM;
        run_random(RANDOM_OPS / 2);
        load_phase <= PH_PRESSURE;
        repeat (PRESS_OPS) send_random_op();
        load_phase <= PH_RANDOM;
        run_random(RANDOM_OPS - RANDOM_OPS / 2);

        // Drain and let any stray result show up
        s_axis_tvalid <= 1'b0;
        load_phase    <= PH_DRAIN;
        @(negedge aclk);
        wait (outstanding == 0);
        repeat (2 * LATENCY) @(posedge aclk);
        @(negedge aclk);

        $display("%0d operations sent, %0d results checked (%0d saturated, %0d zero divisor)",
                 ops_sent, results_checked, saturations, zero_divides);
        $display("all codes incl. unused ones, bursty source, patterned sink, %0d-cycle hold-off",
                 LONG_HOLD);
        if (error_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
